>>> hw/rtl/deq_pkg.sv
// Shared constants, codes and control types of the double-ended queue unit.
package deq_pkg;

	// Queue geometry and field widths.
	localparam int DEPTH      = 16;
	localparam int WORD_BITS  = 32;
	localparam int VALUE_BITS = 32;
	localparam int STORE_BITS = (WORD_BITS < VALUE_BITS) ? WORD_BITS : VALUE_BITS;
	localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int SUM_BITS   = $clog2(2 * DEPTH);

	// Operation codes carried by the kind field.
	typedef enum logic [1:0] {
		KIND_PUSH_FRONT = 2'd0,
		KIND_PUSH_BACK  = 2'd1,
		KIND_POP_FRONT  = 2'd2,
		KIND_POP_BACK   = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POP_EMPTY  = 2'd1,
		STAT_PUSH_FULL  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic finish_pop;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/deq_datapath.sv
// Datapath of the double-ended queue: pointers, storage and result register.
module deq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  deq_pkg::ctrl_cmd_t                  cmd,
	input  deq_pkg::kind_t                      kind,
	input  logic [deq_pkg::VALUE_BITS-1:0]      value,
	input  logic                                out_stall,
	output deq_pkg::dp_stat_t                   stat,
	output logic                                out_valid,
	output logic [deq_pkg::VALUE_BITS-1:0]      popped_value,
	output logic [1:0]                          status,
	output logic                                is_empty
);
	import deq_pkg::*;

	logic [IDX_BITS-1:0]   head_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [IDX_BITS-1:0]   head_d;
	logic [CNT_BITS-1:0]   count_d;
	logic                  empty;
	logic                  full;
	logic [IDX_BITS-1:0]   head_dec;
	logic [IDX_BITS-1:0]   head_inc;
	logic [SUM_BITS-1:0]   sum_back;
	logic [SUM_BITS-1:0]   sum_last;
	logic [IDX_BITS-1:0]   tail_wr;
	logic [IDX_BITS-1:0]   tail_rd;
	logic                  ram_we;
	logic [IDX_BITS-1:0]   ram_waddr;
	logic                  ram_re;
	logic [IDX_BITS-1:0]   ram_raddr;
	logic [STORE_BITS-1:0] ram_rdata;
	logic                  load_out;
	logic [VALUE_BITS-1:0] res_value;
	status_t               res_status;
	logic                  res_empty;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] popped_q;
	status_t               status_q;
	logic                  empty_q;

	// Occupancy flags.
	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_BITS'(DEPTH));

	// Ring index arithmetic; every sum stays below twice the depth.
	assign head_dec = (head_q == '0) ? IDX_BITS'(DEPTH - 1) : head_q - 1'b1;
	assign head_inc = (head_q == IDX_BITS'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign sum_back = SUM_BITS'(head_q) + SUM_BITS'(count_q);
	assign sum_last = sum_back - 1'b1;
	assign tail_wr  = (sum_back >= SUM_BITS'(DEPTH)) ?
		IDX_BITS'(sum_back - SUM_BITS'(DEPTH)) : IDX_BITS'(sum_back);
	assign tail_rd  = (sum_last >= SUM_BITS'(DEPTH)) ?
		IDX_BITS'(sum_last - SUM_BITS'(DEPTH)) : IDX_BITS'(sum_last);

	// Operation decode for an accepted transfer and for a finishing pop.
	always_comb begin
		head_d     = head_q;
		count_d    = count_q;
		ram_we     = 1'b0;
		ram_waddr  = head_dec;
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		load_out   = 1'b0;
		res_value  = '0;
		res_status = STAT_OK;
		res_empty  = empty;
		if (cmd.take) begin
			unique case (kind) inside
				KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
					load_out = 1'b1;
					if (full) begin
						res_status = STAT_PUSH_FULL;
					end else begin
						ram_we    = 1'b1;
						count_d   = count_q + 1'b1;
						res_empty = 1'b0;
						if (kind == KIND_PUSH_FRONT) begin
							head_d    = head_dec;
							ram_waddr = head_dec;
						end else begin
							ram_waddr = tail_wr;
						end
					end
				end
				KIND_POP_FRONT, KIND_POP_BACK: begin
					if (empty) begin
						load_out   = 1'b1;
						res_status = STAT_POP_EMPTY;
					end else begin
						ram_re  = 1'b1;
						count_d = count_q - 1'b1;
						if (kind == KIND_POP_FRONT) begin
							ram_raddr = head_q;
							head_d    = head_inc;
						end else begin
							ram_raddr = tail_rd;
						end
					end
				end
				default: begin
					load_out = 1'b0;
				end
			endcase
		end else if (cmd.finish_pop) begin
			load_out  = 1'b1;
			res_value = VALUE_BITS'(ram_rdata);
			res_empty = empty;
		end
	end

	// Pointer and count registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Entry storage.
	deq_ram #(
		.WIDTH(STORE_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (value[STORE_BITS-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			popped_q <= res_value;
			status_q <= res_status;
			empty_q  <= res_empty;
		end
	end

	assign stat.empty    = empty;
	assign stat.full     = full;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign popped_value = popped_q;
	assign status       = status_q;
	assign is_empty     = empty_q;

endmodule

>>> hw/rtl/deq_ctrl.sv
// Controller state machine of the double-ended queue.
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  deq_pkg::kind_t     kind,
	input  deq_pkg::dp_stat_t  stat,
	output logic               in_stall,
	output deq_pkg::ctrl_cmd_t cmd
);
	import deq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   is_pop;

	assign is_pop   = (kind == KIND_POP_FRONT) || (kind == KIND_POP_BACK);
	assign in_stall = !((state_q == S_IDLE) && stat.out_free);

	assign cmd.take       = in_valid && !in_stall;
	assign cmd.finish_pop = (state_q == S_READ);

	// A pop that finds data passes through S_READ to wait for the registered RAM read.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.take && is_pop && !stat.empty) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue unit.
// A double-ended queue of words held in a ring buffer of DEPTH entries, with a
// head pointer and an entry count in flip-flops. Each input transfer is a push
// or pop at the front or back and yields exactly one result transfer. A push,
// and a pop on an empty queue, load the result register when taken; a pop that
// removes a word holds new items off in a read state for the registered RAM read.
// A push on a full queue is dropped and reported with the full status. The
// entry storage needs no clearing after reset. A finished result waits in the
// output register, and the next item is taken in the cycle that result leaves.
module double_ended_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     kind,
	input  logic [deq_pkg::VALUE_BITS-1:0] value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [deq_pkg::VALUE_BITS-1:0] popped_value,
	output logic [1:0]                     status,
	output logic                           is_empty
);
	import deq_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;
	kind_t     kind_op;

	assign kind_op = kind_t'(kind);

	// Controller.
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind_op),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	// Datapath.
	deq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind_op),
		.value        (value),
		.out_stall    (out_stall),
		.stat         (stat),
		.out_valid    (out_valid),
		.popped_value (popped_value),
		.status       (status),
		.is_empty     (is_empty)
	);

`ifndef SYNTHESIS
	// A pop can only finish right after the transfer that started it.
	a_finish_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish_pop |-> $past(cmd.take))
		else $error("pop finished without a preceding transfer");

	// A transfer is only taken when the result register can hold its result.
	a_take_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> stat.out_free)
		else $error("transfer taken while result register is blocked");

	// A push produces its result in the next cycle.
	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && (kind_op == KIND_PUSH_FRONT || kind_op == KIND_PUSH_BACK))
		|=> out_valid)
		else $error("push result not presented");

	// The queue can never look empty and full at once.
	a_empty_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.empty && stat.full))
		else $error("queue both empty and full");
`endif

endmodule

>>> verif/double_ended_queue_unit_tb.sv
// Self-checking testbench of the double-ended queue unit: directed table, random bursts, scoreboard.
module double_ended_queue_unit_tb;
	import deq_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 650;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 20;
	localparam int DRAIN_CYCLES  = 10;
	localparam int IDLE_LIMIT    = 4000;

	// Idling phases of the run.
	localparam int PH_SLOW_SEND = 0;
	localparam int PH_SLOW_RECV = 1;
	localparam int PH_FREE      = 2;

	// One result transfer as the scoreboard sees it.
	typedef struct packed {
		logic [VALUE_BITS-1:0] popped_value;
		status_t               status;
		logic                  is_empty;
	} deq_result_t;

	// One row of the directed table; a row with reps above one sends its operation reps times, counting value up by one.
	typedef struct {
		kind_t                 kind;
		logic [VALUE_BITS-1:0] value;
		int                    reps;
		bit                    has_exp;
		deq_result_t           exp;
	} dir_row_t;

	localparam int DIR_ROWS = 11;

	dir_row_t directed_rows [DIR_ROWS] = '{
		'{KIND_POP_FRONT,  32'h0000_0000, 1, 1'b1, '{32'h0, STAT_POP_EMPTY, 1'b1}},
		'{KIND_POP_BACK,   32'hFFFF_FFFF, 1, 1'b1, '{32'h0, STAT_POP_EMPTY, 1'b1}},
		'{KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_PUSH_BACK,  32'h0000_0000, 1, 1'b1, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_PUSH_BACK,  32'h5555_0000, 7, 1'b0, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_PUSH_FRONT, 32'hAAAA_0000, 7, 1'b0, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_PUSH_BACK,  32'h1234_5678, 1, 1'b1, '{32'h0, STAT_PUSH_FULL, 1'b0}},
		'{KIND_PUSH_FRONT, 32'hDEAD_BEEF, 1, 1'b1, '{32'h0, STAT_PUSH_FULL, 1'b0}},
		'{KIND_POP_FRONT,  32'h0000_0000, 1, 1'b0, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_POP_BACK,   32'h0000_0000, 1, 1'b0, '{32'h0, STAT_OK, 1'b0}},
		'{KIND_POP_FRONT,  32'h0000_0000, 2, 1'b0, '{32'h0, STAT_OK, 1'b0}}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind = KIND_PUSH_FRONT;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [VALUE_BITS-1:0] popped_value;
	logic [1:0]            status;
	logic                  is_empty;

	// Typed expectation that travels with the item on the input port.
	bit          drv_has_exp = 1'b0;
	deq_result_t drv_exp = '0;

	// Shadow copy of the queue state.
	logic [STORE_BITS-1:0] shadow_entries [DEPTH];
	int                    shadow_head = 0;
	int                    shadow_count = 0;

	deq_result_t pending_results [$];

	int  run_phase = PH_SLOW_SEND;
	bit  hold_req = 1'b0;
	bit  hold_done = 1'b0;
	int  hold_left = 0;
	int  error_count = 0;
	int  items_in = 0;
	int  results_out = 0;
	int  full_drops = 0;
	int  empty_pops = 0;
	int  idle_cycles = 0;

	double_ended_queue_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.popped_value (popped_value),
		.status       (status),
		.is_empty     (is_empty)
	);

	always #(CLK_HALF) clk = ~clk;

	// Applies one operation to the shadow queue and returns the result it gives.
	function automatic deq_result_t predict_deque_step(kind_t op, logic [VALUE_BITS-1:0] word);
		deq_result_t res;
		int          slot;
		res = '0;
		res.status = STAT_OK;
		if (op == KIND_PUSH_FRONT || op == KIND_PUSH_BACK) begin
			if (shadow_count >= DEPTH) begin
				res.status = STAT_PUSH_FULL;
			end else if (op == KIND_PUSH_FRONT) begin
				shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
				shadow_entries[shadow_head] = word[STORE_BITS-1:0];
				shadow_count++;
			end else begin
				slot = (shadow_head + shadow_count) % DEPTH;
				shadow_entries[slot] = word[STORE_BITS-1:0];
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = STAT_POP_EMPTY;
			end else if (op == KIND_POP_FRONT) begin
				res.popped_value = VALUE_BITS'(shadow_entries[shadow_head]);
				shadow_head = (shadow_head + 1) % DEPTH;
				shadow_count--;
			end else begin
				slot = (shadow_head + shadow_count - 1) % DEPTH;
				res.popped_value = VALUE_BITS'(shadow_entries[slot]);
				shadow_count--;
			end
		end
		res.is_empty = (shadow_count == 0);
		return res;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string what, logic [VALUE_BITS-1:0] got,
			logic [VALUE_BITS-1:0] want);
		$display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
			results_out, what, got, want);
		error_count++;
	endtask

	// Offers one item from a falling edge and returns at the falling edge after its transfer.
	task automatic send_item(kind_t op, logic [VALUE_BITS-1:0] word, bit has_exp,
			deq_result_t exp);
		int idle_pct;
		idle_pct = (run_phase == PH_SLOW_SEND) ? 32 : (run_phase == PH_SLOW_RECV) ? 46 : 0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= op;
		value       <= word;
		drv_has_exp <= has_exp;
		drv_exp     <= exp;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Random word with the all-zero and all-one patterns mixed in.
	function automatic logic [VALUE_BITS-1:0] pick_word();
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			return '0;
		else if (sel == 1)
			return '1;
		return $urandom;
	endfunction

	// Scoreboard: results are checked before the same edge's input transfer is predicted.
	always @(posedge clk) begin
		deq_result_t want;
		deq_result_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected, popped_value",
						popped_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (popped_value !== want.popped_value)
						report_mismatch("popped_value", popped_value, want.popped_value);
					if (status !== want.status)
						report_mismatch("status", VALUE_BITS'(status), VALUE_BITS'(want.status));
					if (is_empty !== want.is_empty)
						report_mismatch("is_empty", VALUE_BITS'(is_empty),
							VALUE_BITS'(want.is_empty));
				end
				results_out++;
			end
			if (in_valid && !in_stall) begin
				pred = predict_deque_step(kind_t'(kind), value);
				if (pred.status == STAT_PUSH_FULL)
					full_drops++;
				if (pred.status == STAT_POP_EMPTY)
					empty_pops++;
				pending_results.push_back(drv_has_exp ? drv_exp : pred);
				items_in++;
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Receiver: random stalls per phase, and one long hold-off while the sender keeps offering.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) <
					((run_phase == PH_SLOW_SEND) ? 46 : (run_phase == PH_SLOW_RECV) ? 32 : 0));
			end
		end
	end

	// Reset, directed table, random bursts, then drain and verdict.
	initial begin
		int          mode;
		int          burst_len;
		int          push_pct;
		int          sent;
		int          free_start;
		kind_t       op;
		deq_result_t no_exp;
		no_exp = '0;
		sent = 0;
		free_start = -1;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table.
		foreach (directed_rows[r]) begin
			for (int n = 0; n < directed_rows[r].reps; n++)
				send_item(directed_rows[r].kind, directed_rows[r].value + n,
					directed_rows[r].has_exp, directed_rows[r].exp);
		end

		// Random bursts that lean toward filling, draining or neither, plus noise.
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(7);
			burst_len = $urandom_range(4, 24);
			push_pct = (mode < 3) ? 85 : (mode < 6) ? 15 : 50;
			for (int n = 0; n < burst_len && sent < RANDOM_ITEMS; n++) begin
				run_phase = (sent * 3) / RANDOM_ITEMS;
				if (run_phase == PH_FREE && free_start < 0)
					free_start = sent;
				if (run_phase == PH_FREE && sent >= free_start + HOLD_AFTER)
					hold_req = 1'b1;
				if (mode == 7)
					op = kind_t'($urandom_range(3));
				else if ($urandom_range(99) < push_pct)
					op = $urandom_range(1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
				else
					op = $urandom_range(1) ? KIND_POP_FRONT : KIND_POP_BACK;
				send_item(op, pick_word(), 1'b0, no_exp);
				sent++;
			end
		end
		in_valid <= 1'b0;

		// Drain the scoreboard, then let the pipeline settle.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d item transfers and %0d result transfers.",
			items_in, results_out);
		$display("Full-queue drops: %0d, empty-queue pops: %0d, mismatches: %0d.",
			full_drops, empty_pops, error_count);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
